[hw/rtl/mshd_pkg.sv]
package mshd_pkg;

	// Result kinds
	localparam logic [3:0] KIND_NIL   = 4'd0;
	localparam logic [3:0] KIND_BOOL  = 4'd1;
	localparam logic [3:0] KIND_UINT  = 4'd2;
	localparam logic [3:0] KIND_SINT  = 4'd3;
	localparam logic [3:0] KIND_F32   = 4'd4;
	localparam logic [3:0] KIND_F64   = 4'd5;
	localparam logic [3:0] KIND_MAP   = 4'd6;
	localparam logic [3:0] KIND_ARRAY = 4'd7;
	localparam logic [3:0] KIND_UNSUP = 4'd8;

	// Header codes
	localparam logic [7:0] HDR_NIL     = 8'hc0;
	localparam logic [7:0] HDR_FALSE   = 8'hc2;
	localparam logic [7:0] HDR_TRUE    = 8'hc3;
	localparam logic [7:0] HDR_F32     = 8'hca;
	localparam logic [7:0] HDR_F64     = 8'hcb;
	localparam logic [7:0] HDR_UINT8   = 8'hcc;
	localparam logic [7:0] HDR_UINT16  = 8'hcd;
	localparam logic [7:0] HDR_UINT32  = 8'hce;
	localparam logic [7:0] HDR_UINT64  = 8'hcf;
	localparam logic [7:0] HDR_INT8    = 8'hd0;
	localparam logic [7:0] HDR_INT16   = 8'hd1;
	localparam logic [7:0] HDR_INT32   = 8'hd2;
	localparam logic [7:0] HDR_INT64   = 8'hd3;
	localparam logic [7:0] HDR_ARRAY16 = 8'hdc;
	localparam logic [7:0] HDR_ARRAY32 = 8'hdd;
	localparam logic [7:0] HDR_MAP16   = 8'hde;
	localparam logic [7:0] HDR_MAP32   = 8'hdf;

	// Payload lengths in bytes
	localparam logic [3:0] LEN_1 = 4'd1;
	localparam logic [3:0] LEN_2 = 4'd2;
	localparam logic [3:0] LEN_4 = 4'd4;
	localparam logic [3:0] LEN_8 = 4'd8;

	// What the classifier makes of one header byte
	typedef struct packed {
		logic        emit;
		logic        start;
		logic [3:0]  kind;
		logic [63:0] value;
		logic [3:0]  len;
		logic        sext;
	} hdr_t;

	// One result, qualified by fire
	typedef struct packed {
		logic        fire;
		logic [3:0]  kind;
		logic [63:0] value;
	} res_t;

endpackage

[hw/rtl/mshd_classify.sv]
module mshd_classify
	import mshd_pkg::*;
(
	input  logic [7:0] hdr_byte,
	output hdr_t       hdr
);

	always_comb begin
		hdr = '{emit: 1'b1, start: 1'b0, kind: KIND_UNSUP,
			value: {56'd0, hdr_byte}, len: LEN_1, sext: 1'b0};
		case (hdr_byte) inside
			[8'h00:8'h7f]: begin
				hdr.kind = KIND_UINT;
			end
			[8'h80:8'h8f]: begin
				hdr.kind  = KIND_MAP;
				hdr.value = {60'd0, hdr_byte[3:0]};
			end
			[8'h90:8'h9f]: begin
				hdr.kind  = KIND_ARRAY;
				hdr.value = {60'd0, hdr_byte[3:0]};
			end
			[8'he0:8'hff]: begin
				hdr.kind  = KIND_SINT;
				hdr.value = {{56{1'b1}}, hdr_byte};
			end
			HDR_NIL: begin
				hdr.kind  = KIND_NIL;
				hdr.value = 64'd0;
			end
			HDR_FALSE, HDR_TRUE: begin
				hdr.kind  = KIND_BOOL;
				hdr.value = {63'd0, hdr_byte[0]};
			end
			HDR_F32: begin
				hdr = '{emit: 1'b0, start: 1'b1, kind: KIND_F32,
					value: 64'd0, len: LEN_4, sext: 1'b0};
			end
			HDR_F64: begin
				hdr = '{emit: 1'b0, start: 1'b1, kind: KIND_F64,
					value: 64'd0, len: LEN_8, sext: 1'b0};
			end
			HDR_UINT8, HDR_UINT16, HDR_UINT32, HDR_UINT64,
			HDR_INT8, HDR_INT16, HDR_INT32, HDR_INT64: begin
				hdr.emit  = 1'b0;
				hdr.start = 1'b1;
				hdr.value = 64'd0;
				hdr.sext  = hdr_byte[4];
				hdr.kind  = hdr_byte[4] ? KIND_SINT : KIND_UINT;
				case (hdr_byte[1:0])
					2'd0:    hdr.len = LEN_1;
					2'd1:    hdr.len = LEN_2;
					2'd2:    hdr.len = LEN_4;
					default: hdr.len = LEN_8;
				endcase
			end
			HDR_ARRAY16, HDR_ARRAY32, HDR_MAP16, HDR_MAP32: begin
				hdr.emit  = 1'b0;
				hdr.start = 1'b1;
				hdr.value = 64'd0;
				hdr.kind  = hdr_byte[1] ? KIND_MAP : KIND_ARRAY;
				hdr.len   = hdr_byte[0] ? LEN_4 : LEN_2;
			end
			default: begin
				hdr.kind = KIND_UNSUP;
			end
		endcase
	end

endmodule

[hw/rtl/mshd_collect.sv]
module mshd_collect
	import mshd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       consume,
	input  logic [7:0] byte_s1,
	input  hdr_t       hdr,
	output res_t       res
);

	logic        collecting_q;
	logic [3:0]  bytes_left_q;
	logic [3:0]  kind_q;
	logic        sext_q;
	logic [3:0]  len_q;
	logic [63:0] acc_q;

	logic [63:0] acc_next;
	logic [63:0] final_value;
	logic        last;

	assign acc_next = {acc_q[55:0], byte_s1};
	assign last     = (bytes_left_q <= 4'd1);

	always_comb begin
		final_value = acc_next;
		if (sext_q) begin
			case (len_q)
				LEN_1:   final_value = {{56{acc_next[7]}}, acc_next[7:0]};
				LEN_2:   final_value = {{48{acc_next[15]}}, acc_next[15:0]};
				LEN_4:   final_value = {{32{acc_next[31]}}, acc_next[31:0]};
				default: final_value = acc_next;
			endcase
		end
	end

	always_comb begin
		if (collecting_q) begin
			res.fire  = consume & last;
			res.kind  = kind_q;
			res.value = final_value;
		end else begin
			res.fire  = consume & hdr.emit;
			res.kind  = hdr.kind;
			res.value = hdr.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			bytes_left_q <= 4'd0;
			kind_q       <= KIND_NIL;
			sext_q       <= 1'b0;
			len_q        <= 4'd0;
			acc_q        <= 64'd0;
		end else if (consume) begin
			if (!collecting_q) begin
				if (hdr.start) begin
					collecting_q <= 1'b1;
					bytes_left_q <= hdr.len;
					kind_q       <= hdr.kind;
					sext_q       <= hdr.sext;
					len_q        <= hdr.len;
					acc_q        <= 64'd0;
				end
			end else begin
				acc_q <= acc_next;
				if (bytes_left_q != 4'd0) begin
					bytes_left_q <= bytes_left_q - 4'd1;
				end
				if (last) begin
					collecting_q <= 1'b0;
				end
			end
		end
	end

endmodule

[hw/rtl/msgpack_scalar_header_decoder.sv]
// Channel  Direction  Handshake            Word
// input    in         in_valid / in_ready  data_byte, one stream byte
// output   out        out_valid/out_ready  item_kind, item_value
//
// One byte is taken per cycle when the output side keeps up; the byte that
// completes an item passes through the input register, then the result
// register, before its result appears. A single input register lets one
// byte be taken while a result waits. Reset returns the decoder to awaiting
// a header and empties both registers.
module msgpack_scalar_header_decoder
	import mshd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  item_kind,
	output logic [63:0] item_value
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	logic [3:0]  kind_q;
	logic [63:0] value_q;
	logic        consume;
	hdr_t        hdr;
	res_t        res;

	// The decode step may only run when the result register is free or emptying.
	assign consume  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	mshd_classify u_classify (
		.hdr_byte (byte_s1),
		.hdr      (hdr)
	);

	mshd_collect u_collect (
		.clk     (clk),
		.arst_n  (arst_n),
		.consume (consume),
		.byte_s1 (byte_s1),
		.hdr     (hdr),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume) begin
			out_valid_q <= res.fire;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.fire) begin
			kind_q  <= res.kind;
			value_q <= res.value;
		end
	end

	assign out_valid  = out_valid_q;
	assign item_kind  = kind_q;
	assign item_value = value_q;

endmodule

[hw/rtl/mshd_checker.sv]
module mshd_checker
	import mshd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  item_kind,
	input  logic [63:0] item_value
);

	// A word that is not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(item_value))
		else $error("result word changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> item_kind <= KIND_UNSUP)
		else $error("result kind out of range");

	a_nil_bool: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind == KIND_NIL || item_kind == KIND_BOOL)
		|-> item_value[63:1] == 63'd0 && (item_kind == KIND_BOOL || !item_value[0]))
		else $error("nil or bool with a bad value");

	a_size_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind == KIND_MAP || item_kind == KIND_ARRAY)
		|-> item_value[63:32] == 32'd0)
		else $error("map or array size wider than 32 bits");

	a_unsup_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_UNSUP |-> item_value[63:8] == 56'd0)
		else $error("unsupported result not holding its header byte");

endmodule

bind msgpack_scalar_header_decoder mshd_checker u_mshd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.item_kind  (item_kind),
	.item_value (item_value)
);
